[design/pale_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and helpers for the prefix access list engine.
// Depends on nothing; used by prefix_access_list_engine.
package pale_pkg;

	localparam int DEF_NUM_LISTS      = 128;
	localparam int DEF_RULES_PER_LIST = 16;

	localparam int LIST_W   = 7;
	localparam int LEN_W    = 6;
	localparam int COUNT_W  = 5;
	localparam int IN_W     = 88;
	localparam int OUT_W    = 8;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_DELETE = 2'd2,
		OP_APPLY  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DUP     = 2'd1,
		ST_BADLIST = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             refine;
		logic             exact;
		logic             wild;
		logic             all;
		logic             permit;
	} rule_flags_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] wmask;
		rule_flags_t fl;
	} rule_t;

	function automatic logic [31:0] len_mask(input logic [LEN_W-1:0] len);
		len_mask = ~(32'hFFFF_FFFF >> len);
	endfunction

	function automatic logic rules_equal(input rule_t a, input rule_t b);
		logic [31:0] m;
		m = len_mask(a.fl.len);
		if (a.fl.permit != b.fl.permit)
			rules_equal = 1'b0;
		else if (a.fl.all && b.fl.all)
			rules_equal = 1'b1;
		else if (a.fl.all || b.fl.all)
			rules_equal = 1'b0;
		else
			rules_equal = (a.fl.len == b.fl.len) && (((a.addr ^ b.addr) & m) == 32'd0)
				&& (a.fl.wild == b.fl.wild) && (!a.fl.wild || a.wmask == b.wmask)
				&& (a.fl.exact == b.fl.exact) && (a.fl.refine == b.fl.refine);
	endfunction

	function automatic logic rule_match(input rule_t r, input logic [31:0] addr,
			input logic [LEN_W-1:0] tlen);
		logic [31:0] care;
		logic        len_ok;
		care   = len_mask(r.fl.len) & ~(r.fl.wild ? r.wmask : 32'd0);
		len_ok = (r.fl.refine && tlen > r.fl.len)
			|| ((!r.fl.refine || r.fl.exact) && tlen == r.fl.len);
		rule_match = r.fl.all || (len_ok && (((addr ^ r.addr) & care) == 32'd0));
	endfunction

endpackage

[design/prefix_access_list_engine.sv]
`timescale 1ns / 1ps
// Prefix access list engine: rule store, list status store and scan sequencer.
// Depends on pale_pkg.
//
// channel  dir  tdata                                             tuser
// s_axis   in   list_number,rule_permit,match_all,address,        op
//               prefix_length,has_wildcard,wildcard_mask,
//               exact_flag,refine_flag
// m_axis   out  status,rule_count,permitted                       -
//
// One word passes accept, a list status read, a scan of the list's rules through the
// single compare unit where the op needs one, and a result state; a remove that finds
// its rule then moves the rules behind it up one per cycle through the rule memory
// port. After reset a clearing pass empties each list status store entry in turn,
// with s_axis_tready low.
// m_axis holds its word until taken; a finished word waits in the sequencer meanwhile.
module prefix_access_list_engine #(
	parameter int NUM_LISTS      = pale_pkg::DEF_NUM_LISTS,
	parameter int RULES_PER_LIST = pale_pkg::DEF_RULES_PER_LIST
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// list_number[6:0], rule_permit[7], match_all[8], address[40:9], prefix_length[46:41],
	// has_wildcard[47], wildcard_mask[79:48], exact_flag[80], refine_flag[81], zero fill
	input  logic [pale_pkg::IN_W-1:0]  s_axis_tdata,
	// op[1:0]
	input  logic [1:0]                 s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// status[1:0], rule_count[6:2], permitted[7]
	output logic [pale_pkg::OUT_W-1:0] m_axis_tdata
);

	localparam int CW    = $clog2(RULES_PER_LIST + 1);
	localparam int LW    = $clog2(NUM_LISTS);
	localparam int DEPTH = NUM_LISTS * RULES_PER_LIST;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_META  = 6'b000100,
		S_SCAN  = 6'b001000,
		S_SHIFT = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	pale_pkg::op_t     op_q;
	logic [pale_pkg::LIST_W-1:0] list_q;
	pale_pkg::rule_t   item_q;
	logic [CW-1:0]     idx_q, idx_d;
	logic [LW-1:0]     clr_idx_q;

	pale_pkg::rule_t   rule_mem [DEPTH];
	logic [CW:0]       meta_mem [NUM_LISTS];

	logic              meta_def_s1;
	logic [CW-1:0]     meta_cnt_s1;
	pale_pkg::rule_t   rule_rd_s1;
	logic              rd_valid_s1;
	logic [CW-1:0]     cmp_idx_s1;

	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              rule_wr_en;
	logic [AW-1:0]     rule_wr_addr;
	pale_pkg::rule_t   rule_wr_data;
	logic              meta_wr_en;
	logic [LW-1:0]     meta_wr_idx;
	logic [CW:0]       meta_wr_data;

	pale_pkg::status_t res_status_q, res_status_d;
	logic [CW-1:0]     res_count_q, res_count_d;
	logic              res_permit_q, res_permit_d;

	logic              out_valid_q;
	logic [pale_pkg::OUT_W-1:0] out_data_q;

	logic              accept, out_load, issue, hit, list_oor;
	logic [AW-1:0]     rule_base;
	logic [LW-1:0]     list_idx;
	pale_pkg::rule_t   in_rule;
	logic [pale_pkg::LEN_W-1:0] in_len;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign in_len = (s_axis_tdata[46:41] > pale_pkg::MAX_LEN) ? pale_pkg::MAX_LEN
		: s_axis_tdata[46:41];
	always_comb begin
		in_rule           = '0;
		in_rule.addr      = s_axis_tdata[40:9];
		in_rule.wmask     = s_axis_tdata[79:48];
		in_rule.fl.len    = in_len;
		in_rule.fl.refine = s_axis_tdata[81];
		in_rule.fl.exact  = s_axis_tdata[80];
		in_rule.fl.wild   = s_axis_tdata[47];
		in_rule.fl.all    = s_axis_tdata[8];
		in_rule.fl.permit = s_axis_tdata[7];
	end

	assign list_oor  = (32'(list_q) >= NUM_LISTS);
	assign list_idx  = LW'(list_q);
	assign rule_base = AW'(list_q) * AW'(RULES_PER_LIST);
	assign issue     = (idx_q < meta_cnt_s1);
	assign hit       = (op_q == pale_pkg::OP_APPLY)
		? pale_pkg::rule_match(rule_rd_s1, item_q.addr, item_q.fl.len)
		: pale_pkg::rules_equal(rule_rd_s1, item_q);
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		rd_en        = 1'b0;
		rd_addr      = rule_base + AW'(idx_q);
		rule_wr_en   = 1'b0;
		rule_wr_addr = rule_base + AW'(meta_cnt_s1);
		rule_wr_data = item_q;
		meta_wr_en   = 1'b0;
		meta_wr_idx  = list_idx;
		meta_wr_data = '0;
		res_status_d = res_status_q;
		res_count_d  = res_count_q;
		res_permit_d = res_permit_q;
		case (state_q)
			S_CLEAR: begin
				meta_wr_en  = 1'b1;
				meta_wr_idx = clr_idx_q;
				if (32'(clr_idx_q) == NUM_LISTS - 1)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept)
					state_d = S_META;
			end
			S_META: begin
				res_status_d = pale_pkg::ST_OK;
				res_count_d  = meta_cnt_s1;
				res_permit_d = 1'b0;
				idx_d        = '0;
				state_d      = S_DONE;
				if (list_oor) begin
					res_status_d = pale_pkg::ST_BADLIST;
					res_count_d  = '0;
				end else begin
					case (op_q)
						pale_pkg::OP_ADD: state_d = S_SCAN;
						pale_pkg::OP_REMOVE: begin
							if (meta_def_s1)
								state_d = S_SCAN;
							else
								res_status_d = pale_pkg::ST_BADLIST;
						end
						pale_pkg::OP_DELETE: begin
							if (meta_def_s1) begin
								meta_wr_en  = 1'b1;
								res_count_d = '0;
							end else begin
								res_status_d = pale_pkg::ST_BADLIST;
							end
						end
						pale_pkg::OP_APPLY: begin
							if (list_q == 7'd0)
								res_permit_d = 1'b1;
							else if (meta_def_s1)
								state_d = S_SCAN;
							else
								res_status_d = pale_pkg::ST_BADLIST;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				rd_en = issue;
				idx_d = idx_q + CW'(issue);
				if (rd_valid_s1 && hit) begin
					state_d = S_DONE;
					case (op_q)
						pale_pkg::OP_ADD: res_status_d = pale_pkg::ST_DUP;
						pale_pkg::OP_REMOVE: begin
							meta_wr_en   = 1'b1;
							meta_wr_data = {1'b1, meta_cnt_s1 - CW'(1)};
							res_count_d  = meta_cnt_s1 - CW'(1);
							idx_d        = cmp_idx_s1 + CW'(1);
							state_d      = S_SHIFT;
						end
						default: res_permit_d = rule_rd_s1.fl.permit;
					endcase
				end else if (!issue) begin
					state_d = S_DONE;
					case (op_q)
						pale_pkg::OP_ADD: begin
							if (32'(meta_cnt_s1) >= RULES_PER_LIST) begin
								res_status_d = pale_pkg::ST_FULL;
							end else begin
								rule_wr_en   = 1'b1;
								meta_wr_en   = 1'b1;
								meta_wr_data = {1'b1, meta_cnt_s1 + CW'(1)};
								res_count_d  = meta_cnt_s1 + CW'(1);
							end
						end
						pale_pkg::OP_REMOVE: res_status_d = pale_pkg::ST_BADLIST;
						default: res_permit_d = 1'b0;
					endcase
				end
			end
			S_SHIFT: begin
				rd_en        = issue;
				idx_d        = idx_q + CW'(issue);
				rule_wr_en   = rd_valid_s1;
				rule_wr_addr = rule_base + AW'(cmp_idx_s1 - CW'(1));
				rule_wr_data = rule_rd_s1;
				if (!issue)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (out_load)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rule_rd_s1 <= rule_mem[rd_addr];
		if (rule_wr_en)
			rule_mem[rule_wr_addr] <= rule_wr_data;
		if (accept)
			{meta_def_s1, meta_cnt_s1} <= meta_mem[LW'(s_axis_tdata[6:0])];
		if (meta_wr_en)
			meta_mem[meta_wr_idx] <= meta_wr_data;
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1   <= idx_q;
		idx_q        <= idx_d;
		res_status_q <= res_status_d;
		res_count_q  <= res_count_d;
		res_permit_q <= res_permit_d;
		if (accept) begin
			op_q   <= pale_pkg::op_t'(s_axis_tuser);
			list_q <= s_axis_tdata[6:0];
			item_q <= in_rule;
		end
		if (out_load)
			out_data_q <= {res_permit_q, pale_pkg::COUNT_W'(res_count_q), res_status_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_idx_q   <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= rd_en && (state_d == state_q);
			if (state_q == S_CLEAR)
				clr_idx_q <= clr_idx_q + LW'(1);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	a_accept_meta: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_META)
		else $error("accepted word did not start with a list status read");
	a_rd_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == S_SCAN || state_q == S_SHIFT))
		else $error("rule read data outside a scan");
	a_wr_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rule_wr_en |-> (state_q == S_SCAN || state_q == S_SHIFT))
		else $error("rule store written outside a scan");
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && state_q == S_IDLE))
		else $error("result word not presented");

endmodule

[tb/sv/pale_checker.sv]
`timescale 1ns / 1ps
// Checker for the prefix access list engine: watches both stream channels,
// keeps its own copy of the lists and compares every result word.
// Depends on pale_pkg.
module pale_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	input  logic                       s_axis_tready,
	input  logic [pale_pkg::IN_W-1:0]  s_axis_tdata,
	input  logic [1:0]                 s_axis_tuser,
	input  logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	input  logic [pale_pkg::OUT_W-1:0] m_axis_tdata,
	output int                         fail_count,
	output int                         pending,
	output int                         words_seen
);
	import pale_pkg::*;

	localparam int NL = DEF_NUM_LISTS;
	localparam int RPL = DEF_RULES_PER_LIST;

	typedef struct packed {
		logic       permit;
		logic [4:0] count;
		status_t    status;
	} verdict_t;

	typedef struct {
		logic        permit;
		logic        all;
		logic [31:0] addr;
		logic [5:0]  len;
		logic        wild;
		logic [31:0] wmask;
		logic        exact;
		logic        refine;
	} acl_rule_t;

	acl_rule_t rules[NL][RPL];
	int        nrules[NL];
	bit        defined[NL];
	verdict_t  verdict_q[$];

	function automatic logic [31:0] prefix_mask(input logic [5:0] len);
		return (len == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - len));
	endfunction

	function automatic bit same_rule(input acl_rule_t a, input acl_rule_t b);
		if (a.permit != b.permit) return 0;
		if (a.all && b.all) return 1;
		if (a.all || b.all) return 0;
		if (a.len != b.len) return 0;
		if (((a.addr ^ b.addr) & prefix_mask(a.len)) != 0) return 0;
		if (a.wild != b.wild) return 0;
		if (a.wild && a.wmask != b.wmask) return 0;
		return a.exact == b.exact && a.refine == b.refine;
	endfunction

	function automatic int find_same(input int l, input acl_rule_t r);
		for (int i = 0; i < nrules[l]; i++)
			if (same_rule(rules[l][i], r)) return i;
		return -1;
	endfunction

	function automatic int rule_hit(input acl_rule_t r, input logic [31:0] a,
			input logic [5:0] tl);
		logic [31:0] care;
		bit          len_ok;
		if (r.all) return r.permit;
		len_ok = (r.refine && tl > r.len) || ((!r.refine || r.exact) && tl == r.len);
		if (!len_ok) return -1;
		care = prefix_mask(r.len) & ~(r.wild ? r.wmask : 32'd0);
		if (((a ^ r.addr) & care) != 0) return -1;
		return r.permit;
	endfunction

	function automatic verdict_t run_op(input op_t op, input logic [87:0] d);
		verdict_t  v;
		acl_rule_t r;
		int        l, pos, h;
		v = '{permit: 0, count: 0, status: ST_OK};
		l = d[6:0];
		r.permit = d[7];
		r.all = d[8];
		r.addr = d[40:9];
		r.len = (d[46:41] > 32) ? 6'd32 : d[46:41];
		r.wild = d[47];
		r.wmask = d[79:48];
		r.exact = d[80];
		r.refine = d[81];
		if (l >= NL) begin
			v.status = ST_BADLIST;
			return v;
		end
		case (op)
			OP_ADD: begin
				if (find_same(l, r) >= 0) v.status = ST_DUP;
				else if (nrules[l] >= RPL) v.status = ST_FULL;
				else begin
					rules[l][nrules[l]] = r;
					nrules[l]++;
					defined[l] = 1;
				end
			end
			OP_REMOVE: begin
				pos = defined[l] ? find_same(l, r) : -1;
				if (pos < 0) v.status = ST_BADLIST;
				else begin
					for (int i = pos; i + 1 < nrules[l]; i++) rules[l][i] = rules[l][i+1];
					nrules[l]--;
				end
			end
			OP_DELETE: begin
				if (!defined[l]) v.status = ST_BADLIST;
				else begin
					defined[l] = 0;
					nrules[l] = 0;
				end
			end
			default: begin
				if (l == 0) v.permit = 1;
				else if (!defined[l]) v.status = ST_BADLIST;
				else
					for (int i = 0; i < nrules[l]; i++) begin
						h = rule_hit(rules[l][i], r.addr, r.len);
						if (h >= 0) begin
							v.permit = h[0];
							break;
						end
					end
			end
		endcase
		v.count = 5'(nrules[l]);
		return v;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		words_seen = 0;
		pending = 0;
		for (int i = 0; i < NL; i++) begin
			nrules[i] = 0;
			defined[i] = 0;
		end
	end

	always @(posedge clk) begin
		verdict_t got, want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				words_seen++;
				if (verdict_q.size() == 0) report("unexpected word", got, 0);
				else begin
					want = verdict_q.pop_front();
					if (got.status != want.status) report("status", got.status, want.status);
					if (got.count != want.count) report("rule_count", got.count, want.count);
					if (got.permit != want.permit) report("permitted", got.permit, want.permit);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				verdict_q.push_back(run_op(op_t'(s_axis_tuser), s_axis_tdata));
			pending = verdict_q.size();
		end
	end
endmodule

[tb/sv/tb_prefix_access_list_engine.sv]
`timescale 1ns / 1ps
// Testbench top for the prefix access list engine: clock, reset, directed and
// random command words, random back-pressure and the verdict. Depends on
// pale_pkg, pale_checker and the engine.
module tb_prefix_access_list_engine;
	import pale_pkg::*;

	logic             clk = 0;
	logic             arst_n = 0;
	logic             s_axis_tvalid = 0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic [1:0]       s_axis_tuser = 0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 0;
	logic [OUT_W-1:0] m_axis_tdata;
	int               fail_count, pending, words_seen;
	int               idle_cycles = 0;
	int               sent = 0;
	bit               hold_off = 0;

	always #6 clk = ~clk;

	prefix_access_list_engine uut (.*);

	pale_checker chk (.*);

	logic [31:0] pool_addr[8];
	logic [31:0] pool_wild[4];

	function automatic logic [87:0] pack_cmd(input int l, input bit p, input bit a,
			input logic [31:0] ad, input logic [5:0] len, input bit w,
			input logic [31:0] wm, input bit e, input bit r);
		return {6'd0, r, e, wm, w, len, ad, a, p, 7'(l)};
	endfunction

	task automatic send(input op_t op, input logic [87:0] d);
		int gap;
		gap = $urandom_range(0, 11);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_random(input bit noise);
		int   l;
		op_t  op;
		logic [5:0] len;
		if (noise) begin
			send(op_t'($urandom_range(0, 3)), {6'd0, 32'($urandom), 32'($urandom),
				11'($urandom), 7'($urandom)});
			return;
		end
		l = $urandom_range(0, 5);
		if ($urandom_range(0, 9) == 0) l = $urandom_range(0, 127);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: op = OP_ADD;
			4, 5: op = OP_REMOVE;
			6: op = OP_DELETE;
			default: op = OP_APPLY;
		endcase
		len = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
			: 6'(8 * $urandom_range(0, 4));
		send(op, pack_cmd(l, 1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0,
			pool_addr[$urandom_range(0, 7)] ^ ($urandom_range(0, 3) == 0 ? $urandom : 32'd0),
			len, $urandom_range(0, 3) == 0, pool_wild[$urandom_range(0, 3)],
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
	endtask

	always @(negedge clk) begin
		if (hold_off) m_axis_tready <= 0;
		else if (m_axis_tvalid && m_axis_tready) m_axis_tready <= ($urandom_range(0, 2) == 0);
		else if (!m_axis_tready) m_axis_tready <= ($urandom_range(0, 11) == 0);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		hold_off = 0;
		wait (sent >= 300);
		@(posedge clk);
		hold_off = 1;
		repeat (400) @(posedge clk);
		hold_off = 0;
	end

	initial begin
		for (int i = 0; i < 8; i++) pool_addr[i] = $urandom;
		pool_addr[0] = 32'h0;
		pool_addr[1] = 32'hFFFF_FFFF;
		pool_wild[0] = 0;
		pool_wild[1] = 32'hFFFF_FFFF;
		pool_wild[2] = 32'h0000_00FF;
		pool_wild[3] = $urandom;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		send(OP_APPLY, pack_cmd(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(OP_APPLY, pack_cmd(1, 0, 0, 0, 0, 0, 0, 0, 0));
		send(OP_REMOVE, pack_cmd(1, 1, 0, 0, 8, 0, 0, 0, 0));
		send(OP_DELETE, pack_cmd(1, 0, 0, 0, 0, 0, 0, 0, 0));
		send(OP_ADD, pack_cmd(127, 1, 0, 32'hFFFF_FFFF, 32, 1, 32'hFFFF_FFFF, 1, 1));
		send(OP_ADD, pack_cmd(1, 1, 0, 32'h0A00_0000, 8, 0, 0, 0, 0));
		send(OP_ADD, pack_cmd(1, 1, 0, 32'h0AFF_FFFF, 8, 0, 0, 0, 0));
		send(OP_ADD, pack_cmd(1, 0, 0, 32'hC0A8_0000, 16, 0, 0, 1, 1));
		send(OP_ADD, pack_cmd(1, 1, 0, 32'hAC10_0000, 63, 1, 32'h000F_FFFF, 0, 1));
		send(OP_ADD, pack_cmd(1, 0, 1, 0, 0, 0, 0, 0, 0));
		send(OP_ADD, pack_cmd(1, 0, 1, 32'h1234, 5, 1, 1, 1, 0));
		send(OP_APPLY, pack_cmd(1, 0, 0, 32'h0A01_0203, 8, 0, 0, 0, 0));
		send(OP_APPLY, pack_cmd(1, 0, 0, 32'hC0A8_0101, 24, 0, 0, 0, 0));
		send(OP_APPLY, pack_cmd(1, 0, 0, 32'hC0A8_0101, 16, 0, 0, 0, 0));
		send(OP_APPLY, pack_cmd(1, 0, 0, 32'hAC1F_0000, 40, 0, 0, 0, 0));
		send(OP_APPLY, pack_cmd(1, 0, 0, 32'h0808_0808, 32, 0, 0, 0, 0));
		for (int i = 0; i < 17; i++)
			send(OP_ADD, pack_cmd(2, i[0], 0, i << 24, 8, 0, 0, 0, 0));
		send(OP_REMOVE, pack_cmd(2, 1, 0, 32'h0300_0000, 8, 0, 0, 0, 0));
		send(OP_REMOVE, pack_cmd(1, 0, 1, 0, 0, 0, 0, 0, 0));
		send(OP_DELETE, pack_cmd(2, 0, 0, 0, 0, 0, 0, 0, 0));
		for (int i = 0; i < 750; i++) send_random($urandom_range(0, 9) == 0);
		s_axis_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("sent %0d command words, checked %0d result words", sent, words_seen);
		$display("covered add, remove, delete and apply with random stalls and a long hold");
		if (fail_count == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
